// ----- hdl/button_short_long_press_detector_assert.svh -----
// Assertion macros for the button short and long press detector.
// Used by the top level; needs a clock named clk and a reset named arst_n in scope.
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSLPD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BSLPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BSLPD_ASSERT_SAME(label, ante, cons)
`define BSLPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/bslpd_pkg.sv -----
// Shared constants and types of the button short and long press detector.
// No dependencies.
`timescale 1ns / 1ps
package bslpd_pkg;
	localparam int NUM_BUTTONS = 7;
	localparam int COUNT_WIDTH = 16;
	localparam int THR_WIDTH = 16;
	localparam int CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
	localparam int BTN_SET = 0;
	localparam int BTN_RESET = 1;
	localparam logic [NUM_BUTTONS-1:0] LONG_MASK = NUM_BUTTONS'(3);
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(100);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	localparam count_t COUNT_MAX = '1;
endpackage

// ----- hdl/button_short_long_press_detector.sv -----
// Button short and long press detector: one poll tick in, one event item out.
// Depends on bslpd_pkg and button_short_long_press_detector_assert.svh.
`timescale 1ns / 1ps
`include "button_short_long_press_detector_assert.svh"

// Each input item is one poll tick. It is captured in an input register, evaluated
// combinationally against the per-button hold counters, and its events land in an output
// register. The block takes one item per clock while the output is not stalled; the counters
// are updated in a single stage. The input side stalls only while a result waits in the output
// register and the next tick is also held.
module button_short_long_press_detector import bslpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [6:0] button_levels, [7] zero
	input  logic                 s_axis_tuser,  // [0] idle_mode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [15:0]          m_axis_tdata,  // [6:0] short_events, [7] set_long_event,
	                                            // [8] reset_long_event, [15:9] zero
	input  logic                 cfg_wr_en,
	input  logic [THR_WIDTH-1:0] cfg_wr_data
);

	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] levels_s1;
	logic                   idle_s1;
	logic                   advance;

	logic [THR_WIDTH-1:0]   thr_q;
	count_t                 held_q [NUM_BUTTONS];
	count_t                 held_d [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] fired_q;
	logic [NUM_BUTTONS-1:0] fired_d;
	logic [NUM_BUTTONS-1:0] short_d;
	logic [NUM_BUTTONS-1:0] long_d;

	logic                   out_valid_q;
	logic [NUM_BUTTONS-1:0] out_short_q;
	logic                   out_set_long_q;
	logic                   out_reset_long_q;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			levels_s1 <= s_axis_tdata[NUM_BUTTONS-1:0];
			idle_s1   <= s_axis_tuser;
		end
	end

	always_comb begin
		count_t inc;
		inc     = '0;
		fired_d = fired_q;
		short_d = '0;
		long_d  = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			held_d[i] = held_q[i];
			if (!idle_s1 || i == BTN_SET) begin
				if (!levels_s1[i]) begin
					inc       = (held_q[i] == COUNT_MAX) ? held_q[i] : held_q[i] + 1'b1;
					held_d[i] = inc;
					if (LONG_MASK[i] && (CMP_WIDTH'(inc) > CMP_WIDTH'(thr_q))) begin
						held_d[i]  = '0;
						fired_d[i] = 1'b1;
						long_d[i]  = 1'b1;
					end
				end else if (held_q[i] != '0) begin
					held_d[i] = '0;
					if (LONG_MASK[i] && fired_q[i]) begin
						fired_d[i] = 1'b0;
					end else begin
						short_d[i] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				held_q[i] <= '0;
			end
			fired_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					held_q[i] <= held_d[i];
				end
				fired_q <= fired_d & LONG_MASK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_short_q      <= short_d;
			out_set_long_q   <= long_d[BTN_SET];
			out_reset_long_q <= long_d[BTN_RESET];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_reset_long_q, out_set_long_q, out_short_q};

	`BSLPD_ASSERT_SAME(a_set_long_flag, out_valid_q && out_set_long_q, fired_q[BTN_SET])
	`BSLPD_ASSERT_SAME(a_set_excl, out_valid_q && out_set_long_q, !out_short_q[BTN_SET])
	`BSLPD_ASSERT_NEXT(a_idle_quiet, advance && valid_s1 && idle_s1,
		out_short_q[NUM_BUTTONS-1:1] == '0 && !out_reset_long_q)
	`BSLPD_ASSERT_SAME(a_stall_full, !s_axis_tready, out_valid_q && valid_s1)

endmodule
